// ===== hw/rtl/mfhc_pkg.sv =====
// Shared types, codes and constants of the media frame header checker.
`timescale 1ns / 1ps

package mfhc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CMP_W      = COUNT_BITS + 2;
    localparam int HDR_MIN    = 4;
    localparam int PLEN_MAX   = 65535;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        REG_MAX_FRAME_BYTES      = 3'd0,
        REG_EXPECTED_VERSION     = 3'd1,
        REG_TYPE_FIRST           = 3'd2,
        REG_TYPE_LAST            = 3'd3,
        REG_HELLO_CODE           = 3'd4,
        REG_HELLO_PAYLOAD_LENGTH = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_VERSION       = 3'd0,
        KIND_TYPE          = 3'd1,
        KIND_SENDER_LEN    = 3'd2,
        KIND_SENDER_ID     = 3'd3,
        KIND_RECIPIENT_LEN = 3'd4,
        KIND_RECIPIENT_ID  = 3'd5,
        KIND_PAYLOAD       = 3'd6
    } field_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_LONG      = 3'd2,
        ERR_VERSION   = 3'd3,
        ERR_TYPE      = 3'd4,
        ERR_SENDER    = 3'd5,
        ERR_RECIPIENT = 3'd6,
        ERR_HELLO     = 3'd7
    } error_code_t;

    localparam logic [15:0] RST_MAX_FRAME_BYTES      = 16'd1200;
    localparam logic [7:0]  RST_EXPECTED_VERSION     = 8'd1;
    localparam logic [7:0]  RST_TYPE_FIRST           = 8'd0;
    localparam logic [7:0]  RST_TYPE_LAST            = 8'd6;
    localparam logic [7:0]  RST_HELLO_CODE           = 8'd0;
    localparam logic [15:0] RST_HELLO_PAYLOAD_LENGTH = 16'd32;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic [7:0]  expected_version;
        logic [7:0]  type_first;
        logic [7:0]  type_last;
        logic [7:0]  hello_code;
        logic [15:0] hello_payload_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        field_kind_t field_kind;
        logic        frame_end;
        logic        frame_ok;
        error_code_t error_code;
        logic [7:0]  frame_type;
        logic [7:0]  sender_length;
        logic [7:0]  recipient_length;
        logic [15:0] payload_length;
    } result_t;

endpackage

// ===== hw/rtl/mfhc_if.sv =====
// Stream and configuration channel interfaces of the header checker.
`timescale 1ns / 1ps

interface mfhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mfhc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  field_kind;
    logic        frame_end;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  frame_type;
    logic [7:0]  sender_length;
    logic [7:0]  recipient_length;
    logic [15:0] payload_length;

    modport source (
        output valid, output byte_out, output field_kind, output frame_end,
        output frame_ok, output error_code, output frame_type, output sender_length,
        output recipient_length, output payload_length, input ready
    );
    modport sink (
        input valid, input byte_out, input field_kind, input frame_end,
        input frame_ok, input error_code, input frame_type, input sender_length,
        input recipient_length, input payload_length, output ready
    );
endinterface

interface mfhc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

// ===== hw/rtl/mfhc_cfg_regs.sv =====
// Configuration register file of the header checker.
`timescale 1ns / 1ps

module mfhc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    mfhc_cfg_if.sink      cfg,
    output mfhc_pkg::cfg_t regs
);
    import mfhc_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.max_frame_bytes      <= RST_MAX_FRAME_BYTES;
            regs_reg.expected_version     <= RST_EXPECTED_VERSION;
            regs_reg.type_first           <= RST_TYPE_FIRST;
            regs_reg.type_last            <= RST_TYPE_LAST;
            regs_reg.hello_code           <= RST_HELLO_CODE;
            regs_reg.hello_payload_length <= RST_HELLO_PAYLOAD_LENGTH;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_FRAME_BYTES:      regs_reg.max_frame_bytes      <= cfg.value;
                REG_EXPECTED_VERSION:     regs_reg.expected_version     <= cfg.value[7:0];
                REG_TYPE_FIRST:           regs_reg.type_first           <= cfg.value[7:0];
                REG_TYPE_LAST:            regs_reg.type_last            <= cfg.value[7:0];
                REG_HELLO_CODE:           regs_reg.hello_code           <= cfg.value[7:0];
                REG_HELLO_PAYLOAD_LENGTH: regs_reg.hello_payload_length <= cfg.value;
                default:                  ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/mfhc_frame_core.sv =====
// Per-frame state, field tagging and verdict logic of the header checker.
`timescale 1ns / 1ps

module mfhc_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  mfhc_pkg::cfg_t    regs,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output mfhc_pkg::result_t result
);
    import mfhc_pkg::*;

    count_t      count_reg, count_next;
    logic [7:0]  sender_len_reg, sender_len_next;
    logic [7:0]  recipient_len_reg, recipient_len_next;
    logic [7:0]  type_reg, type_next;
    error_code_t first_error_reg, first_error_next;
    logic        overflow_reg, overflow_next;

    logic        at_max;
    count_t      count_inc;
    cmp_t        pos_w;
    cmp_t        s_end;
    cmp_t        r_last;
    cmp_t        total_w;
    cmp_t        r_pos;
    cmp_t        r_end;
    cmp_t        plen_full;
    logic [15:0] plen;
    field_kind_t kind;
    error_code_t err;

    always_comb
    begin
        at_max             = (count_reg == COUNT_MAX);
        overflow_next      = overflow_reg | at_max;
        count_inc          = at_max ? count_reg : count_reg + count_t'(1);
        pos_w              = cmp_t'(count_reg);
        s_end              = cmp_t'(sender_len_reg) + cmp_t'(3);
        r_last             = s_end + cmp_t'(recipient_len_reg);
        type_next          = type_reg;
        sender_len_next    = sender_len_reg;
        recipient_len_next = recipient_len_reg;
        first_error_next   = first_error_reg;

        if (overflow_next)
        begin
            kind = KIND_PAYLOAD;
        end
        else if (count_reg == count_t'(0))
        begin
            kind = KIND_VERSION;
            if (data_byte != regs.expected_version && first_error_reg == ERR_NONE)
            begin
                first_error_next = ERR_VERSION;
            end
        end
        else if (count_reg == count_t'(1))
        begin
            kind      = KIND_TYPE;
            type_next = data_byte;
            if ((data_byte < regs.type_first || data_byte > regs.type_last)
                && first_error_reg == ERR_NONE)
            begin
                first_error_next = ERR_TYPE;
            end
        end
        else if (count_reg == count_t'(2))
        begin
            kind            = KIND_SENDER_LEN;
            sender_len_next = data_byte;
        end
        else if (pos_w < s_end)
        begin
            kind = KIND_SENDER_ID;
        end
        else if (pos_w == s_end)
        begin
            kind               = KIND_RECIPIENT_LEN;
            recipient_len_next = data_byte;
        end
        else if (pos_w <= r_last)
        begin
            kind = KIND_RECIPIENT_ID;
        end
        else
        begin
            kind = KIND_PAYLOAD;
        end

        total_w   = cmp_t'(count_inc);
        r_pos     = cmp_t'(sender_len_next) + cmp_t'(HDR_MIN);
        r_end     = r_pos + cmp_t'(recipient_len_next);
        plen_full = (total_w >= r_end) ? total_w - r_end : '0;
        plen      = (32'(plen_full) > 32'(PLEN_MAX)) ? 16'(PLEN_MAX) : 16'(plen_full);

        if (total_w < cmp_t'(HDR_MIN))
            err = ERR_SHORT;
        else if (overflow_next || 32'(count_inc) > 32'(regs.max_frame_bytes))
            err = ERR_LONG;
        else if (first_error_next != ERR_NONE)
            err = first_error_next;
        else if (r_pos > total_w)
            err = ERR_SENDER;
        else if (r_end > total_w)
            err = ERR_RECIPIENT;
        else if (type_next == regs.hello_code && plen != regs.hello_payload_length)
            err = ERR_HELLO;
        else
            err = ERR_NONE;

        if (!last_byte)
        begin
            err  = ERR_NONE;
            plen = '0;
        end

        count_next                = count_inc;
        result.byte_out           = data_byte;
        result.field_kind         = kind;
        result.frame_end          = last_byte;
        result.frame_ok           = last_byte && (err == ERR_NONE);
        result.error_code         = err;
        result.frame_type         = type_next;
        result.sender_length      = sender_len_next;
        result.recipient_length   = recipient_len_next;
        result.payload_length     = plen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            sender_len_reg    <= '0;
            recipient_len_reg <= '0;
            type_reg          <= '0;
            first_error_reg   <= ERR_NONE;
            overflow_reg      <= 1'b0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                // clear for the next datagram
                count_reg         <= '0;
                sender_len_reg    <= '0;
                recipient_len_reg <= '0;
                type_reg          <= '0;
                first_error_reg   <= ERR_NONE;
                overflow_reg      <= 1'b0;
            end
            else
            begin
                count_reg         <= count_next;
                sender_len_reg    <= sender_len_next;
                recipient_len_reg <= recipient_len_next;
                type_reg          <= type_next;
                first_error_reg   <= first_error_next;
                overflow_reg      <= overflow_next;
            end
        end
    end

endmodule

// ===== hw/rtl/media_frame_header_checker_top.sv =====
// Throughput: one byte word per cycle while the result channel is not stalled.
// An input register and a result register part the two channels; a stalled result
// holds one further word in the input register.
// Reset (rst_n low, asynchronous) empties both registers, clears the frame state
// and loads the configuration reset values.
`timescale 1ns / 1ps

module media_frame_header_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    mfhc_in_if.sink     data,
    mfhc_out_if.source  result,
    mfhc_cfg_if.sink    cfg
);
    import mfhc_pkg::*;

    cfg_t       regs;
    result_t    core_result;
    result_t    out_result_reg;
    logic       out_valid_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       advance;

    mfhc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mfhc_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .advance   (advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .result    (core_result)
    );

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign data.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (data.valid && data.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data.valid && data.ready)
        begin
            s1_byte_reg <= data.data_byte;
            s1_last_reg <= data.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.byte_out         = out_result_reg.byte_out;
    assign result.field_kind       = out_result_reg.field_kind;
    assign result.frame_end        = out_result_reg.frame_end;
    assign result.frame_ok         = out_result_reg.frame_ok;
    assign result.error_code       = out_result_reg.error_code;
    assign result.frame_type       = out_result_reg.frame_type;
    assign result.sender_length    = out_result_reg.sender_length;
    assign result.recipient_length = out_result_reg.recipient_length;
    assign result.payload_length   = out_result_reg.payload_length;

endmodule

// ===== tb/sv/tb_media_frame_header_checker_top.sv =====
// Self-checking testbench of the media frame header checker: random and directed datagrams.
`timescale 1ns / 1ps

module tb_media_frame_header_checker_top;
    import mfhc_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int BLOCK_WORDS   = 95;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 40;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef logic [7:0] byte_q_t[$];

    class verdict_board;
        cfg_t        cfg;
        count_t      count;
        logic [7:0]  sender_len;
        logic [7:0]  recipient_len;
        logic [7:0]  frame_type;
        error_code_t first_err;
        logic        overflow;
        result_t     expected_words[$];
        int          mismatches;

        function new();
            cfg.max_frame_bytes      = RST_MAX_FRAME_BYTES;
            cfg.expected_version     = RST_EXPECTED_VERSION;
            cfg.type_first           = RST_TYPE_FIRST;
            cfg.type_last            = RST_TYPE_LAST;
            cfg.hello_code           = RST_HELLO_CODE;
            cfg.hello_payload_length = RST_HELLO_PAYLOAD_LENGTH;
            mismatches = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            count         = '0;
            sender_len    = '0;
            recipient_len = '0;
            frame_type    = '0;
            first_err     = ERR_NONE;
            overflow      = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_MAX_FRAME_BYTES:      cfg.max_frame_bytes = val;
                REG_EXPECTED_VERSION:     cfg.expected_version = val[7:0];
                REG_TYPE_FIRST:           cfg.type_first = val[7:0];
                REG_TYPE_LAST:            cfg.type_last = val[7:0];
                REG_HELLO_CODE:           cfg.hello_code = val[7:0];
                REG_HELLO_PAYLOAD_LENGTH: cfg.hello_payload_length = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Tag one accepted byte, judge the datagram on its last byte, queue the word.
        function void predict_tag(logic [7:0] b, logic last);
            result_t     w;
            field_kind_t kind;
            error_code_t err;
            int          pos;
            int          s_end;
            int          r_pos;
            int          r_end;
            int          total;
            int          plen;
            pos = count;
            if (count == COUNT_MAX)
                overflow = 1'b1;
            else
                count = count + 1'b1;
            s_end = 3 + sender_len;
            if (overflow)
                kind = KIND_PAYLOAD;
            else if (pos == 0)
            begin
                kind = KIND_VERSION;
                if (b != cfg.expected_version && first_err == ERR_NONE)
                    first_err = ERR_VERSION;
            end
            else if (pos == 1)
            begin
                kind = KIND_TYPE;
                frame_type = b;
                if ((b < cfg.type_first || b > cfg.type_last) && first_err == ERR_NONE)
                    first_err = ERR_TYPE;
            end
            else if (pos == 2)
            begin
                kind = KIND_SENDER_LEN;
                sender_len = b;
            end
            else if (pos < s_end)
                kind = KIND_SENDER_ID;
            else if (pos == s_end)
            begin
                kind = KIND_RECIPIENT_LEN;
                recipient_len = b;
            end
            else if (pos <= s_end + recipient_len)
                kind = KIND_RECIPIENT_ID;
            else
                kind = KIND_PAYLOAD;

            err  = ERR_NONE;
            plen = 0;
            if (last)
            begin
                total = count;
                r_pos = HDR_MIN + sender_len;
                r_end = r_pos + recipient_len;
                if (total >= r_end)
                    plen = total - r_end;
                if (plen > PLEN_MAX)
                    plen = PLEN_MAX;
                if (total < HDR_MIN)
                    err = ERR_SHORT;
                else if (overflow || total > cfg.max_frame_bytes)
                    err = ERR_LONG;
                else if (first_err != ERR_NONE)
                    err = first_err;
                else if (r_pos > total)
                    err = ERR_SENDER;
                else if (r_end > total)
                    err = ERR_RECIPIENT;
                else if (frame_type == cfg.hello_code && plen != cfg.hello_payload_length)
                    err = ERR_HELLO;
            end

            w.byte_out         = b;
            w.field_kind       = kind;
            w.frame_end        = last;
            w.frame_ok         = last && (err == ERR_NONE);
            w.error_code       = err;
            w.frame_type       = frame_type;
            w.sender_length    = sender_len;
            w.recipient_length = recipient_len;
            w.payload_length   = 16'(plen);
            expected_words.push_back(w);
            if (last)
                restart_frame();
        endfunction

        function void check_field(string what, logic [15:0] want, logic [15:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
            end
        endfunction

        function void compare_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t: word expected none, got byte_out %0h", $time, got.byte_out);
                return;
            end
            want = expected_words.pop_front();
            check_field("byte_out", want.byte_out, got.byte_out);
            check_field("field_kind", want.field_kind, got.field_kind);
            check_field("frame_end", want.frame_end, got.frame_end);
            check_field("frame_ok", want.frame_ok, got.frame_ok);
            check_field("error_code", want.error_code, got.error_code);
            check_field("frame_type", want.frame_type, got.frame_type);
            check_field("sender_length", want.sender_length, got.sender_length);
            check_field("recipient_length", want.recipient_length, got.recipient_length);
            check_field("payload_length", want.payload_length, got.payload_length);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    logic hold_pending;

    verdict_board board;

    mfhc_in_if  data_if ();
    mfhc_out_if result_if ();
    mfhc_cfg_if cfg_if ();

    media_frame_header_checker_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #5 clk = ~clk;

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            data_if.valid     <= 1'b0;
            data_if.data_byte <= 8'($urandom);
            data_if.last_byte <= 1'($urandom);
            @(posedge clk);
        end
        data_if.valid     <= 1'b1;
        data_if.data_byte <= b;
        data_if.last_byte <= last;
        do @(posedge clk); while (!data_if.ready);
        board.predict_tag(b, last);
    endtask

    task automatic send_frame(input byte_q_t f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic drain();
        data_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.value <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic configure(input cfg_t s);
        drain();
        write_reg(REG_MAX_FRAME_BYTES, s.max_frame_bytes);
        write_reg(REG_EXPECTED_VERSION, 16'(s.expected_version));
        write_reg(REG_TYPE_FIRST, 16'(s.type_first));
        write_reg(REG_TYPE_LAST, 16'(s.type_last));
        write_reg(REG_HELLO_CODE, 16'(s.hello_code));
        write_reg(REG_HELLO_PAYLOAD_LENGTH, s.hello_payload_length);
    endtask

    function automatic cfg_t pick_settings(int n);
        cfg_t s;
        s.max_frame_bytes      = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(8, 300));
        s.expected_version     = 8'($urandom);
        s.type_first           = 8'($urandom_range(0, 200));
        s.type_last            = 8'(s.type_first + $urandom_range(0, 55));
        s.hello_code           = 8'($urandom_range(s.type_last, s.type_first));
        s.hello_payload_length = 16'($urandom_range(0, 6));
        if (n == 0)
        begin
            s.max_frame_bytes  = RST_MAX_FRAME_BYTES;
            s.expected_version = RST_EXPECTED_VERSION;
            s.type_first       = RST_TYPE_FIRST;
            s.type_last        = RST_TYPE_LAST;
            s.hello_code       = RST_HELLO_CODE;
        end
        else if (n == 1)
        begin
            s.max_frame_bytes  = 16'($urandom_range(4, 30));
            s.expected_version = 8'hFF;
            s.type_first       = 8'hFF;
            s.type_last        = 8'hFF;
            s.hello_code       = 8'hFF;
            s.hello_payload_length = 16'd0;
        end
        else if (n == 3 || n == 6)
        begin
            s.type_first = 8'($urandom_range(1, 255));
            s.type_last  = 8'($urandom_range(0, s.type_first - 1));
            s.hello_code = 8'($urandom);
        end
        return s;
    endfunction

    task automatic send_random_frame(output int n);
        byte_q_t    f;
        int         sl;
        int         rl;
        int         pl;
        logic [7:0] t;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                f.push_back(8'($urandom));
        end
        else
        begin
            f.push_back(($urandom_range(9) == 0) ? 8'($urandom) : board.cfg.expected_version);
            if ($urandom_range(2) == 0)
                t = board.cfg.hello_code;
            else
                t = 8'($urandom_range(board.cfg.type_last, board.cfg.type_first));
            if ($urandom_range(15) == 0)
                t = 8'($urandom);
            f.push_back(t);
            sl = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
            rl = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
            f.push_back(8'(sl));
            repeat (sl)
                f.push_back(8'($urandom));
            f.push_back(8'(rl));
            repeat (rl)
                f.push_back(8'($urandom));
            if (t == board.cfg.hello_code && board.cfg.hello_payload_length <= 64
                && $urandom_range(3) != 0)
                pl = board.cfg.hello_payload_length;
            else
                pl = $urandom_range(12);
            repeat (pl)
                f.push_back(8'($urandom));
            // truncate now and then
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(f.size() - 1))
                    void'(f.pop_back());
        end
        send_frame(f);
        n = f.size();
    endtask

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.byte_out         = result_if.byte_out;
            got.field_kind       = field_kind_t'(result_if.field_kind);
            got.frame_end        = result_if.frame_end;
            got.frame_ok         = result_if.frame_ok;
            got.error_code       = error_code_t'(result_if.error_code);
            got.frame_type       = result_if.frame_type;
            got.sender_length    = result_if.sender_length;
            got.recipient_length = result_if.recipient_length;
            got.payload_length   = result_if.payload_length;
            board.compare_word(got);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
                result_if.ready <= 1'b0;
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((data_if.valid && data_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int      sent;
        int      n;
        cfg_t    s;
        board = new();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_pending = 1'b0;
        rst_n = 1'b0;
        data_if.valid = 1'b0;
        data_if.data_byte = '0;
        data_if.last_byte = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: short, version, type, sender, recipient, hello, good
        send_frame('{8'd1});
        send_frame('{8'd0, 8'd7, 8'd0, 8'd0});
        send_frame('{8'd1, 8'd7, 8'd0, 8'd0});
        send_frame('{8'd1, 8'd6, 8'd5, 8'd0});
        send_frame('{8'd1, 8'd6, 8'd0, 8'd3, 8'hAA});
        send_frame('{8'd1, 8'd0, 8'd0, 8'd0});
        send_frame('{8'd1, 8'd6, 8'd1, 8'h5A, 8'd1, 8'hA5, 8'hFF});

        // maximum below the header size, empty type range, spare indexes
        s.max_frame_bytes      = 16'd2;
        s.expected_version     = 8'hFF;
        s.type_first           = 8'd9;
        s.type_last            = 8'd8;
        s.hello_code           = 8'hFF;
        s.hello_payload_length = 16'd0;
        configure(s);
        write_reg(REG_SPARE_LO, 16'h0000);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        send_frame('{8'hFF, 8'd8, 8'd0, 8'd0});
        send_frame('{8'hFF, 8'd8});
        s.max_frame_bytes = 16'd4;
        s.hello_code      = 8'd8;
        configure(s);
        send_frame('{8'hFF, 8'd8, 8'd0, 8'd0});

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int blk = 0; blk < 2; blk++)
            begin
                configure(pick_settings(2 * ph + blk));
                case (ph)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 45; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 45; end
                    default: begin send_idle_pct = 21; stall_pct = 21; end
                endcase
                // hold the output off while bytes keep coming
                if (ph == 0 && blk == 0)
                    hold_pending = 1'b1;
                sent = 0;
                while (sent < BLOCK_WORDS)
                begin
                    send_random_frame(n);
                    sent += n;
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
